// File: hw/rtl/sdvn_pkg.sv
// Package for the sample-delta von Neumann extractor.
// Holds shared widths, payload types and the absolute-delta function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sdvn_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int BYTE_W      = 8;
  localparam int COUNT_W     = 3;
  localparam int POS_W       = 4;
  localparam int QUEUE_DEPTH = 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [SAMPLE_W-1:0]        delta_t;
  typedef logic [BYTE_W-1:0]          byte_t;
  typedef logic [COUNT_W-1:0]         count_t;
  typedef logic [POS_W-1:0]           pos_t;

  // Low 16 bits of |now - prev| on sign-extended samples
  function automatic delta_t abs_delta(input sample_t now, input sample_t prev);
    logic signed [SAMPLE_W:0] diff;
    logic signed [SAMPLE_W:0] mag;
    diff = {now[SAMPLE_W-1], now} - {prev[SAMPLE_W-1], prev};
    mag  = diff[SAMPLE_W] ? -diff : diff;
    return mag[SAMPLE_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sdvn_if.sv
// Handshake interfaces for the extractor: stereo frame channel and result word channel.
// Depends on sdvn_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sdvn_frame_if;
  import sdvn_pkg::*;

  logic    valid;
  logic    ready;
  sample_t left_sample;
  sample_t right_sample;
  logic    buffer_start;

  modport source (output valid, output left_sample, output right_sample,
                  output buffer_start, input ready);
  modport sink   (input valid, input left_sample, input right_sample,
                  input buffer_start, output ready);
endinterface

interface sdvn_result_if;
  import sdvn_pkg::*;

  logic  valid;
  logic  ready;
  byte_t random_byte;
  logic  source_channel;
  pos_t  bit_position;
  logic  last;

  modport source (output valid, output random_byte, output source_channel,
                  output bit_position, output last, input ready);
  modport sink   (input valid, input random_byte, input source_channel,
                  input bit_position, input last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sample_delta_von_neumann_extractor.sv
// A frame's first result word passes through the queue entry, the back end's lane mask
// register and the output register before it is offered.
// Throughput: a frame each cycle while the two-entry queue has room; words drain at one
// per cycle from the back end while the result channel is not stalled.
// Reset (rst, synchronous): clears stored samples, all debiaser lanes, queue and output.
// Depends on sdvn_pkg, sdvn_if, sdvn_front, sdvn_queue, sdvn_back.
`timescale 1ns / 1ps
`default_nettype none

module sample_delta_von_neumann_extractor #(
  parameter int BIT_LANES = 16,
  parameter int CHANNELS  = 2
) (
  input  logic          clk,
  input  logic          rst,
  sdvn_frame_if.sink    frame,
  sdvn_result_if.source result
);
  import sdvn_pkg::*;

  localparam int LANES = CHANNELS * BIT_LANES;
  localparam int QW    = LANES + LANES * BYTE_W;

  logic              push_valid;
  logic              push_ready;
  logic [LANES-1:0]  push_mask;
  byte_t [LANES-1:0] push_bytes;
  logic              pop_valid;
  logic              pop_ready;
  logic [QW-1:0]     pop_data;
  logic [LANES-1:0]  pop_mask;
  byte_t [LANES-1:0] pop_bytes;

  assign pop_mask  = pop_data[QW-1 -: LANES];
  assign pop_bytes = pop_data[LANES*BYTE_W-1:0];

  sdvn_front #(
    .BIT_LANES (BIT_LANES),
    .CHANNELS  (CHANNELS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame.valid),
    .frame_ready  (frame.ready),
    .left_sample  (frame.left_sample),
    .right_sample (frame.right_sample),
    .buffer_start (frame.buffer_start),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_mask    (push_mask),
    .push_bytes   (push_bytes)
  );

  sdvn_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_mask, push_bytes}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  sdvn_back #(
    .BIT_LANES (BIT_LANES),
    .CHANNELS  (CHANNELS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .job_valid      (pop_valid),
    .job_ready      (pop_ready),
    .job_mask       (pop_mask),
    .job_bytes      (pop_bytes),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .random_byte    (result.random_byte),
    .source_channel (result.source_channel),
    .bit_position   (result.bit_position),
    .last           (result.last)
  );

endmodule

`default_nettype wire

// File: hw/rtl/sdvn_front.sv
// Front end: accepts frames, forms per-channel deltas and runs all debiaser lanes.
// Completed bytes of one frame leave as a lane mask plus byte snapshot. Depends on sdvn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdvn_front #(
  parameter int BIT_LANES = 16,
  parameter int CHANNELS  = 2
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              frame_valid,
  output logic                              frame_ready,
  input  sdvn_pkg::sample_t                 left_sample,
  input  sdvn_pkg::sample_t                 right_sample,
  input  logic                              buffer_start,
  output logic                              push_valid,
  input  logic                              push_ready,
  output logic [CHANNELS*BIT_LANES-1:0]     push_mask,
  output sdvn_pkg::byte_t [CHANNELS*BIT_LANES-1:0] push_bytes
);
  import sdvn_pkg::*;

  localparam int LANES = CHANNELS * BIT_LANES;

  sample_t prev_sample [2];
  logic    have_prev;
  delta_t  delta [2];
  logic    accept;
  logic    step;

  logic   pend_valid [LANES];
  logic   pend_bit   [LANES];
  count_t bits_cnt   [LANES];
  byte_t  assembly   [LANES];
  logic [LANES-1:0] done;

  assign frame_ready = push_ready;
  assign accept      = frame_valid && frame_ready;
  assign step        = accept && !buffer_start && have_prev;
  assign push_valid  = step && (|done);
  assign push_mask   = done;

  // Form both channel deltas against the stored samples
  always_comb begin
    delta[0] = abs_delta(left_sample, prev_sample[0]);
    delta[1] = abs_delta(right_sample, prev_sample[1]);
  end

  // Store samples on every accepted frame
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample[0] <= '0;
      prev_sample[1] <= '0;
      have_prev      <= 1'b0;
    end else if (accept) begin
      prev_sample[0] <= left_sample;
      prev_sample[1] <= right_sample;
      have_prev      <= 1'b1;
    end
  end

  // One debiaser per channel and bit position
  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_ch
    for (genvar ln = 0; ln < BIT_LANES; ln++) begin : g_lane
      localparam int K = ch * BIT_LANES + ln;
      logic  lane_bit;
      logic  emit_bit;
      byte_t merged;

      assign lane_bit = delta[ch][ln];
      assign emit_bit = pend_valid[K] && (pend_bit[K] != lane_bit);
      assign merged   = assembly[K] | (byte_t'(pend_bit[K]) << bits_cnt[K]);
      assign done[K]  = emit_bit && (bits_cnt[K] == count_t'(BYTE_W - 1));
      assign push_bytes[K] = merged;

      // Pair up bits, drop equal pairs, fill the byte LSB first
      always_ff @(posedge clk) begin
        if (rst) begin
          pend_valid[K] <= 1'b0;
          pend_bit[K]   <= 1'b0;
          bits_cnt[K]   <= '0;
          assembly[K]   <= '0;
        end else if (step) begin
          if (!pend_valid[K]) begin
            pend_valid[K] <= 1'b1;
            pend_bit[K]   <= lane_bit;
          end else begin
            pend_valid[K] <= 1'b0;
            if (emit_bit) begin
              bits_cnt[K] <= bits_cnt[K] + count_t'(1);
              assembly[K] <= done[K] ? '0 : merged;
            end
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sdvn_queue.sv
// Short queue between front and back: holds per-frame completion mask and byte snapshot.
// Depends on sdvn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdvn_queue #(
  parameter int WIDTH = 288
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import sdvn_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] store [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = store[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Write the entry at the tail
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sdvn_back.sv
// Back end: drains one frame's completed bytes, left lanes first, one word per cycle
// unless stalled. Output register decouples the result channel. Depends on sdvn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdvn_back #(
  parameter int BIT_LANES = 16,
  parameter int CHANNELS  = 2
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     job_valid,
  output logic                                     job_ready,
  input  logic [CHANNELS*BIT_LANES-1:0]            job_mask,
  input  sdvn_pkg::byte_t [CHANNELS*BIT_LANES-1:0] job_bytes,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output sdvn_pkg::byte_t                          random_byte,
  output logic                                     source_channel,
  output sdvn_pkg::pos_t                           bit_position,
  output logic                                     last
);
  import sdvn_pkg::*;

  localparam int LANES = CHANNELS * BIT_LANES;

  logic [LANES-1:0]  cur_mask;
  byte_t [LANES-1:0] cur_bytes;
  logic [LANES-1:0]  sel;
  logic [LANES-1:0]  rest;
  byte_t             sel_byte;
  logic              sel_chan;
  pos_t              sel_pos;
  logic              sel_last;
  logic              fire;

  // Pick the lowest pending lane
  assign sel      = cur_mask & (~cur_mask + LANES'(1));
  assign rest     = cur_mask & ~sel;
  assign sel_last = (rest == '0);
  assign fire     = (cur_mask != '0) && (!out_valid || out_ready);
  assign job_ready = (cur_mask == '0) || (fire && sel_last);

  // Mux byte, channel and position of the selected lane
  always_comb begin
    sel_byte = '0;
    sel_chan = 1'b0;
    sel_pos  = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      for (int ln = 0; ln < BIT_LANES; ln++) begin
        if (sel[ch * BIT_LANES + ln]) begin
          sel_byte = sel_byte | cur_bytes[ch * BIT_LANES + ln];
          sel_chan = sel_chan | 1'(ch);
          sel_pos  = sel_pos | POS_W'(ln);
        end
      end
    end
  end

  // Load the next frame's bytes or retire the emitted lane
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mask <= '0;
    end else if (job_valid && job_ready) begin
      cur_mask <= job_mask;
    end else if (fire) begin
      cur_mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      cur_bytes <= job_bytes;
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      random_byte    <= sel_byte;
      source_channel <= sel_chan;
      bit_position   <= sel_pos;
      last           <= sel_last;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sdvn_checker.sv
// Port-level checks for the extractor and the bind that attaches them to the top level.
// Depends on sdvn_pkg and sample_delta_von_neumann_extractor.
`timescale 1ns / 1ps
`default_nettype none

module sdvn_checker #(
  parameter int BIT_LANES = 16,
  parameter int CHANNELS  = 2
) (
  input wire                  clk,
  input wire                  rst,
  input wire                  result_valid,
  input wire                  result_ready,
  input wire sdvn_pkg::byte_t random_byte,
  input wire                  source_channel,
  input wire sdvn_pkg::pos_t  bit_position,
  input wire                  last
);
  import sdvn_pkg::*;

  // A stalled word stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result word withdrawn while stalled");

  // A stalled word keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(random_byte) && $stable(bit_position)
      && $stable(source_channel) && $stable(last))
    else $error("result payload changed while stalled");

  // Words of one frame follow back to back until the last one
  a_burst: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && !last |=> result_valid)
    else $error("gap inside a frame's result burst");

  // Lane and channel stay within the configured lanes
  a_lane_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (int'(bit_position) < BIT_LANES) && (int'(source_channel) < CHANNELS))
    else $error("result names a lane that does not exist");

endmodule

bind sample_delta_von_neumann_extractor sdvn_checker #(
  .BIT_LANES (BIT_LANES),
  .CHANNELS  (CHANNELS)
) u_sdvn_checker (
  .clk            (clk),
  .rst            (rst),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .random_byte    (result.random_byte),
  .source_channel (result.source_channel),
  .bit_position   (result.bit_position),
  .last           (result.last)
);

`default_nettype wire

// File: sim/sample_delta_von_neumann_extractor_test.sv
// Self-checking testbench for the sample-delta von Neumann extractor.
// Predicts the debiased bytes per frame and checks every result word; uses sdvn_pkg and sdvn_if.
`timescale 1ns / 1ps

module sample_delta_von_neumann_extractor_test;
  import sdvn_pkg::*;

  localparam int LANES_PER_CH = 16;
  localparam int LANE_COUNT   = 2 * LANES_PER_CH;
  localparam int QUIET_LIMIT  = 3000;
  localparam int STALL_CYCLES = 300;
  localparam int DRAIN_CYCLES = 50;

  typedef struct {
    byte_t random_byte;
    logic  source_channel;
    pos_t  bit_position;
    logic  last;
  } result_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sdvn_frame_if  frame_bus ();
  sdvn_result_if result_bus ();

  sample_delta_von_neumann_extractor u_top (
    .clk    (clk),
    .rst    (rst),
    .frame  (frame_bus),
    .result (result_bus)
  );

  // Predicted state of the extractor
  sample_t stored_sample [2];
  logic    have_stored;
  logic    lane_pending [LANE_COUNT];
  logic    lane_first [LANE_COUNT];
  count_t  lane_fill [LANE_COUNT];
  byte_t   lane_byte [LANE_COUNT];

  result_word_t expected_words [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_request = 0;
  int fail_count    = 0;
  int frames_sent   = 0;
  int starts_sent   = 0;
  int words_checked = 0;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the debiaser lanes for one accepted frame and queue the bytes it completes
  function automatic void predict_debiased_bytes(input sample_t l_smp, input sample_t r_smp,
                                                 input logic start);
    sample_t      now [2];
    delta_t       delta [2];
    result_word_t produced [$];
    result_word_t w;
    int           diff;
    int           k;
    logic         cur;
    now[0] = l_smp;
    now[1] = r_smp;
    // Store only: buffer start, or the first frame after reset
    if (start || !have_stored) begin
      stored_sample[0] = now[0];
      stored_sample[1] = now[1];
      have_stored = 1'b1;
      return;
    end
    for (int ch = 0; ch < 2; ch++) begin
      diff = int'(now[ch]) - int'(stored_sample[ch]);
      if (diff < 0) diff = -diff;
      delta[ch] = delta_t'(diff);
      stored_sample[ch] = now[ch];
    end
    // Scan left lanes first, then right, each in ascending order
    for (int ch = 0; ch < 2; ch++) begin
      for (int lane = 0; lane < LANES_PER_CH; lane++) begin
        k = ch * LANES_PER_CH + lane;
        cur = delta[ch][lane];
        if (!lane_pending[k]) begin
          lane_pending[k] = 1'b1;
          lane_first[k] = cur;
        end else begin
          lane_pending[k] = 1'b0;
          // Drop equal pairs; 10 gives a one, 01 a zero
          if (lane_first[k] != cur) begin
            if (lane_first[k]) lane_byte[k][lane_fill[k]] = 1'b1;
            if (lane_fill[k] == count_t'(7)) begin
              w.random_byte = lane_byte[k];
              w.source_channel = logic'(ch);
              w.bit_position = pos_t'(lane);
              w.last = 1'b0;
              produced.push_back(w);
              lane_fill[k] = '0;
              lane_byte[k] = '0;
            end else begin
              lane_fill[k] = lane_fill[k] + count_t'(1);
            end
          end
        end
      end
    end
    for (int i = 0; i < produced.size(); i++) begin
      w = produced[i];
      w.last = (i == produced.size() - 1);
      expected_words.push_back(w);
    end
  endfunction

  // Pick a sample: extremes, values near zero or anything at all
  function automatic sample_t pick_sample();
    case ($urandom_range(9))
      0: return sample_t'(16'h8000);
      1: return sample_t'(16'h7FFF);
      2, 3: return sample_t'($urandom_range(16) - 8);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Offer one frame after a random gap and hold it until accepted
  task automatic send_frame(input sample_t l_smp, input sample_t r_smp, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      frame_bus.valid <= 1'b0;
      @(posedge clk);
    end
    frame_bus.valid        <= 1'b1;
    frame_bus.left_sample  <= l_smp;
    frame_bus.right_sample <= r_smp;
    frame_bus.buffer_start <= start;
    do @(posedge clk); while (frame_bus.ready !== 1'b1);
    predict_debiased_bytes(l_smp, r_smp, start);
    frames_sent++;
    if (start) starts_sent++;
  endtask

  // A frame right after reset without a start mark only stores its samples
  task automatic test_first_frame_stores();
    send_frame(sample_t'(1234), sample_t'(-1234), 1'b0);
  endtask

  // Alternate full-scale and zero deltas: every lane of both channels fills 0xFF at once
  task automatic test_full_scale_bytes();
    sample_t v;
    send_frame(sample_t'(16'h8000), sample_t'(16'h7FFF), 1'b1);
    for (int i = 1; i <= 16; i++) begin
      v = (((i + 1) / 2) % 2 == 1) ? sample_t'(16'h7FFF) : sample_t'(16'h8000);
      send_frame(v, ~v, 1'b0);
    end
  endtask

  // Zero then full-scale delta gives zeros; a buffer start mid-pair keeps lane state
  task automatic test_restart_mid_pair();
    send_frame(sample_t'(0), sample_t'(0), 1'b1);
    send_frame(sample_t'(0), sample_t'(0), 1'b0);
    send_frame(sample_t'(16'h8000), sample_t'(16'h7FFF), 1'b1);
    send_frame(sample_t'(16'h7FFF), sample_t'(16'h8000), 1'b0);
  endtask

  // Mostly continuing frames with an occasional new buffer
  task automatic test_random_frames(input int count);
    for (int i = 0; i < count; i++)
      send_frame(pick_sample(), pick_sample(), logic'($urandom_range(99) < 4));
  endtask

  // Hold off the output for a long stretch while frames keep coming
  task automatic test_output_backpressure();
    stall_request = STALL_CYCLES;
    test_random_frames(20);
  endtask

  // Check each accepted word against the oldest prediction, then drive ready
  always @(posedge clk) begin : result_check
    result_word_t want;
    int           stall_left;
    if (!rst && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word: byte %h channel %0d position %0d",
               result_bus.random_byte, result_bus.source_channel, result_bus.bit_position);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (result_bus.random_byte !== want.random_byte) begin
          $error("random_byte: expected %h, actual %h", want.random_byte,
                 result_bus.random_byte);
          fail_count++;
        end
        if (result_bus.source_channel !== want.source_channel) begin
          $error("source_channel: expected %0d, actual %0d", want.source_channel,
                 result_bus.source_channel);
          fail_count++;
        end
        if (result_bus.bit_position !== want.bit_position) begin
          $error("bit_position: expected %0d, actual %0d", want.bit_position,
                 result_bus.bit_position);
          fail_count++;
        end
        if (result_bus.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, result_bus.last);
          fail_count++;
        end
      end
    end
    if (stall_request != 0) begin
      stall_left = stall_request;
      stall_request = 0;
    end
    if (stall_left > 0) begin
      result_bus.ready <= 1'b0;
      stall_left--;
    end else begin
      result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // End the run when nothing moves on either side for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((frame_bus.valid === 1'b1 && frame_bus.ready === 1'b1) ||
          (result_bus.valid === 1'b1 && result_bus.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    frame_bus.valid        = 1'b0;
    frame_bus.left_sample  = '0;
    frame_bus.right_sample = '0;
    frame_bus.buffer_start = 1'b0;
    result_bus.ready       = 1'b0;
    stored_sample[0] = '0;
    stored_sample[1] = '0;
    have_stored = 1'b0;
    for (int k = 0; k < LANE_COUNT; k++) begin
      lane_pending[k] = 1'b0;
      lane_first[k]   = 1'b0;
      lane_fill[k]    = '0;
      lane_byte[k]    = '0;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Slow sender, mostly stalled receiver
    send_idle_pct = 35;
    recv_idle_pct = 86;
    test_first_frame_stores();
    test_full_scale_bytes();
    test_restart_mid_pair();
    test_random_frames(60);

    // Mostly idle sender, quick receiver
    send_idle_pct = 86;
    recv_idle_pct = 35;
    test_random_frames(60);

    // Full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(50);
    test_output_backpressure();
    frame_bus.valid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d frames (%0d buffer starts) under three idling mixes and a %0d-cycle",
             frames_sent, starts_sent, STALL_CYCLES);
    $display("output stall; %0d result words checked, %0d mismatches.", words_checked,
             fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
